[hw/rtl/pls_pkg.sv]
`default_nettype none

package pls_pkg;

  // List geometry
  localparam int unsigned CAPACITY   = 16;
  localparam int unsigned DATA_WIDTH = 32;

  // Fixed field widths
  localparam int unsigned KIND_W   = 3;
  localparam int unsigned POS_W    = 5;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 5;

  // Internal widths derived from the geometry
  localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned CMP_W = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

  // Operation codes
  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 3'd0,
    KIND_REMOVE = 3'd1,
    KIND_READ   = 3'd2,
    KIND_WRITE  = 3'd3,
    KIND_CLEAR  = 3'd4
  } kind_e;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_DONE   = 2'd0,
    ST_BADPOS = 2'd1,
    ST_FULL   = 2'd2
  } status_e;

  // What the row of cells does this cycle
  typedef enum logic [1:0] {
    ACT_NONE   = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_REMOVE = 2'd2,
    ACT_WRITE  = 2'd3
  } cell_act_e;

  // Command broadcast to every cell
  typedef struct packed {
    cell_act_e             act;
    logic [IDX_W-1:0]      idx;
    logic [DATA_WIDTH-1:0] value;
  } cell_cmd_t;

endpackage

`default_nettype wire

[hw/rtl/pls_if.sv]
`default_nettype none

// Request channel: one list operation per transfer
interface pls_in_if;
  import pls_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [KIND_W-1:0]     kind;
  logic [POS_W-1:0]      position;
  logic [DATA_WIDTH-1:0] value;

  modport source (output valid, output kind, output position, output value, input ready);
  modport sink   (input valid, input kind, input position, input value, output ready);
endinterface

// Response channel: one result per operation
interface pls_out_if;
  import pls_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [STATUS_W-1:0]   status;
  logic [DATA_WIDTH-1:0] read_value;
  logic [COUNT_W-1:0]    count;
  logic                  empty_res;

  modport source (output valid, output status, output read_value, output count,
                  output empty_res, input ready);
  modport sink   (input valid, input status, input read_value, input count,
                  input empty_res, output ready);
endinterface

`default_nettype wire

[hw/rtl/pls_cell.sv]
`default_nettype none

// One list slot. Loads a new value, takes its neighbour's entry or holds.
module pls_cell (
  input  logic                           clk_i,
  input  logic [pls_pkg::IDX_W-1:0]      idx_i,
  input  pls_pkg::cell_cmd_t             cmd_i,
  input  logic [pls_pkg::DATA_WIDTH-1:0] prev_i,
  input  logic [pls_pkg::DATA_WIDTH-1:0] next_i,
  output logic [pls_pkg::DATA_WIDTH-1:0] data_o
);
  import pls_pkg::*;

  logic [DATA_WIDTH-1:0] data_d, data_q;

  // Slot update from the broadcast command and this slot's index
  always_comb begin
    data_d = data_q;
    unique case (cmd_i.act)
      ACT_INSERT: begin
        if (idx_i == cmd_i.idx) begin
          data_d = cmd_i.value;
        end else if (idx_i > cmd_i.idx) begin
          data_d = prev_i;
        end
      end
      ACT_REMOVE: begin
        if (idx_i >= cmd_i.idx) begin
          data_d = next_i;
        end
      end
      ACT_WRITE: begin
        if (idx_i == cmd_i.idx) begin
          data_d = cmd_i.value;
        end
      end
      default: data_d = data_q;
    endcase
  end

  // Payload only, no reset
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

[hw/rtl/positional_list_store_top.sv]
`default_nettype none

// Channel  Dir  Payload                                    Transfer when
// in_i     in   kind[2:0] position[4:0] value[31:0]         in_i.valid & in_i.ready
// out_o    out  status[1:0] read_value[31:0] count[4:0]     out_o.valid & out_o.ready
//                empty_res
//
// One operation per cycle while the held result is taken or none is held: all slots
// shift at once in the row of cells, so an insert or remove does not depend on the position.
// Result appears in the cycle after the request transfer, from the output register.
// A new request is taken while the held result is being taken in the same cycle.
// Reset clears the entry count and the output valid; slot contents are not reset.
module positional_list_store_top (
  input  logic      clk_i,
  input  logic      rst_ni,
  pls_in_if.sink    in_i,
  pls_out_if.source out_o
);
  import pls_pkg::*;

  logic                  accept;
  logic                  out_vld_q;
  logic [CNT_W-1:0]      cnt_d, cnt_q;
  logic [CMP_W-1:0]      pos_x, cnt_x;
  logic                  pos_zero, in_range, ins_range;
  logic [POS_W-1:0]      pos_m1;
  status_e               status_d;
  logic [DATA_WIDTH-1:0] rd_d;
  cell_act_e             act_d;
  cell_cmd_t             cmd;

  logic [STATUS_W-1:0]   status_q;
  logic [DATA_WIDTH-1:0] rd_q;
  logic [COUNT_W-1:0]    count_q;
  logic                  empty_q;

  logic [DATA_WIDTH-1:0] cell_data [CAPACITY];

  assign in_i.ready = !out_vld_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  // Position checks against the current count
  assign pos_x     = CMP_W'(in_i.position);
  assign cnt_x     = CMP_W'(cnt_q);
  assign pos_zero  = (in_i.position == '0);
  assign in_range  = !pos_zero && (pos_x <= cnt_x);
  assign ins_range = !pos_zero && (pos_x <= cnt_x + CMP_W'(1));
  assign pos_m1    = in_i.position - POS_W'(1);

  // Operation decode
  always_comb begin
    status_d = ST_BADPOS;
    rd_d     = '0;
    cnt_d    = cnt_q;
    act_d    = ACT_NONE;
    unique case (in_i.kind)
      KIND_INSERT: begin
        if (!ins_range) begin
          status_d = ST_BADPOS;
        end else if (cnt_q == CNT_W'(CAPACITY)) begin
          status_d = ST_FULL;
        end else begin
          status_d = ST_DONE;
          act_d    = ACT_INSERT;
          cnt_d    = cnt_q + CNT_W'(1);
        end
      end
      KIND_REMOVE: begin
        if (in_range) begin
          status_d = ST_DONE;
          act_d    = ACT_REMOVE;
          cnt_d    = cnt_q - CNT_W'(1);
        end
      end
      KIND_READ: begin
        if (in_range) begin
          status_d = ST_DONE;
          rd_d     = cell_data[pos_m1[IDX_W-1:0]];
        end
      end
      KIND_WRITE: begin
        if (in_range) begin
          status_d = ST_DONE;
          act_d    = ACT_WRITE;
        end
      end
      KIND_CLEAR: begin
        status_d = ST_DONE;
        cnt_d    = '0;
      end
      default: status_d = ST_BADPOS;
    endcase
  end

  // Broadcast to the cells only on a request transfer
  assign cmd.act   = accept ? act_d : ACT_NONE;
  assign cmd.idx   = pos_m1[IDX_W-1:0];
  assign cmd.value = in_i.value;

  // Row of cells linked to their neighbours; the first sees zero below, the last sees itself above
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] prev, next;
    if (i == 0) begin : g_first
      assign prev = '0;
    end else begin : g_prev
      assign prev = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign next = cell_data[i];
    end else begin : g_next
      assign next = cell_data[i+1];
    end
    pls_cell u_cell (
      .clk_i  (clk_i),
      .idx_i  (IDX_W'(i)),
      .cmd_i  (cmd),
      .prev_i (prev),
      .next_i (next),
      .data_o (cell_data[i])
    );
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (accept) begin
      cnt_q     <= cnt_d;
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      rd_q     <= rd_d;
      count_q  <= COUNT_W'(cnt_d);
      empty_q  <= (cnt_d == '0);
    end
  end

  assign out_o.valid      = out_vld_q;
  assign out_o.status     = status_q;
  assign out_o.read_value = rd_q;
  assign out_o.count      = count_q;
  assign out_o.empty_res  = empty_q;

endmodule

`default_nettype wire

[hw/rtl/pls_checker.sv]
`default_nettype none

module pls_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_ready_i,
  input  logic                           out_valid_i,
  input  logic                           out_ready_i,
  input  logic [pls_pkg::STATUS_W-1:0]   out_status_i,
  input  logic [pls_pkg::DATA_WIDTH-1:0] out_read_value_i,
  input  logic [pls_pkg::COUNT_W-1:0]    out_count_i,
  input  logic                           out_empty_res_i
);
  import pls_pkg::*;

  // Held result stays put until transferred
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_status_i)
      && $stable(out_read_value_i) && $stable(out_count_i))
    else $error("result changed while stalled");

  // No back-pressure while the output register is empty
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("request stalled with empty output register");

  // Empty flag follows the count
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_empty_res_i == (out_count_i == '0)))
    else $error("empty flag disagrees with count");

  // Full refusal only at capacity, and count never exceeds it
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_count_i <= COUNT_W'(CAPACITY))
      && ((out_status_i != ST_FULL) || (out_count_i == COUNT_W'(CAPACITY))))
    else $error("count or full status out of line");

  // Data only comes back on a successful operation
  a_rd_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_status_i != ST_DONE) |-> (out_read_value_i == '0))
    else $error("read data on a refused operation");

endmodule

bind positional_list_store_top pls_checker u_pls_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_ready_i       (in_i.ready),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .out_status_i     (out_o.status),
  .out_read_value_i (out_o.read_value),
  .out_count_i      (out_o.count),
  .out_empty_res_i  (out_o.empty_res)
);

`default_nettype wire
